/* sv/okc_pkg.sv */
// Shared types and constants for the octal keypad console controller.
// Holds the key, pending-access and command codes and the packed word layouts.
// No dependencies.
package okc_pkg;

  localparam int MICRO_PC_WIDTH = 9;
  // micro-PC bits kept from the 9-bit input field
  localparam logic [8:0] MPC_MASK = 9'((1 << MICRO_PC_WIDTH) - 1);

  localparam logic [17:0] REG_LO    = 18'h3FFC0;
  localparam logic [17:0] REG_HI    = 18'h3FFC7;
  localparam logic [17:0] EVEN_MASK = 18'h3FFFE;

  // item kinds
  localparam logic [1:0] MODE_KEY  = 2'd0;
  localparam logic [1:0] MODE_ACC  = 2'd1;
  localparam logic [1:0] MODE_STEP = 2'd2;
  localparam logic [1:0] MODE_TICK = 2'd3;

  // key codes
  localparam logic [4:0] KEY_DIGIT_MAX = 5'd7;
  localparam logic [4:0] KEY_ADD_SW    = 5'd6;
  localparam logic [4:0] KEY_ADD_PTR   = 5'd7;
  localparam logic [4:0] KEY_MAINT     = 5'd1;
  localparam logic [4:0] KEY_CLR       = 5'd8;
  localparam logic [4:0] KEY_LAD       = 5'd9;
  localparam logic [4:0] KEY_LSR       = 5'd10;
  localparam logic [4:0] KEY_DISAD     = 5'd11;
  localparam logic [4:0] KEY_VIEW      = 5'd12;
  localparam logic [4:0] KEY_DEP       = 5'd13;
  localparam logic [4:0] KEY_HALT      = 5'd14;
  localparam logic [4:0] KEY_PROCEED   = 5'd15;
  localparam logic [4:0] KEY_LOAD_BOOT = 5'd16;
  localparam logic [4:0] KEY_RUN       = 5'd17;
  localparam logic [4:0] KEY_SYSINIT   = 5'd18;
  localparam logic [4:0] KEY_CTRL      = 5'd19;

  // pending operation
  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_READ  = 2'd1;
  localparam logic [1:0] PEND_WRITE = 2'd2;
  localparam logic [1:0] PEND_STEP  = 2'd3;

  // access commands
  localparam logic [2:0] ACC_NONE    = 3'd0;
  localparam logic [2:0] ACC_BUS_RD  = 3'd1;
  localparam logic [2:0] ACC_BUS_WR  = 3'd2;
  localparam logic [2:0] ACC_REG_RD  = 3'd3;
  localparam logic [2:0] ACC_REG_WR  = 3'd4;

  // cpu commands
  localparam logic [2:0] CPU_NONE  = 3'd0;
  localparam logic [2:0] CPU_HALT  = 3'd1;
  localparam logic [2:0] CPU_CONT  = 3'd2;
  localparam logic [2:0] CPU_START = 3'd3;
  localparam logic [2:0] CPU_STEP  = 3'd4;
  localparam logic [2:0] CPU_USTEP = 3'd5;
  localparam logic [2:0] CPU_BOOT  = 3'd6;
  localparam logic [2:0] CPU_INIT  = 3'd7;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 80;

  // input word, lowest field last
  typedef struct packed {
    logic [5:0]                pad;
    logic [15:0]               cpu_bus_data;
    logic [17:0]               cpu_bus_address;
    logic [8:0]                micro_pc;
    logic                      cpu_halted;
    logic                      access_error;
    logic [15:0]               read_data;
    logic [4:0]                key_code;
  } in_data_t;

  typedef struct packed {
    logic [1:0] mode;
    in_data_t   data;
  } in_item_t;

  // result word, lowest field last
  typedef struct packed {
    logic [2:0]  cpu_command;
    logic [15:0] access_write_data;
    logic [17:0] access_address;
    logic [2:0]  access_command;
    logic        manual_clock;
    logic        control_armed;
    logic        maintenance_light;
    logic        switch_display_light;
    logic        bus_error_light;
    logic        run_light;
    logic [15:0] switch_value;
    logic [17:0] display_value;
  } out_item_t;

  typedef struct packed {
    logic adv;   // result register can load
    logic fire;  // held word moves into the result register
  } stage_ctl_t;

endpackage

/* sv/okc_in_stage.sv */
// Input register of the console controller: holds one accepted word.
// Depends on okc_pkg.
module okc_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  okc_pkg::in_item_t  in_item,
  input  okc_pkg::stage_ctl_t ctl,
  output logic               held_valid,
  output okc_pkg::in_item_t  held_item
);
  import okc_pkg::*;

  logic     valid_r, valid_nxt;
  in_item_t item_r;

  assign in_ready   = !valid_r || ctl.adv;
  assign held_valid = valid_r;
  assign held_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

/* sv/okc_core.sv */
// Console state and per-word update logic: keypad decode, access and command issue.
// Depends on okc_pkg.
module okc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  okc_pkg::stage_ctl_t ctl,
  input  okc_pkg::in_item_t   item,
  output okc_pkg::out_item_t  result
);
  import okc_pkg::*;

  logic [17:0] entry_r, entry_nxt;
  logic [17:0] ptr_r, ptr_nxt;
  logic [17:0] shown_r, shown_nxt;
  logic [15:0] sw_r, sw_nxt;
  logic        exam_r, exam_nxt;
  logic        dep_r, dep_nxt;
  logic        mclk_r, mclk_nxt;
  logic        prefix_r, prefix_nxt;
  logic        maint_r, maint_nxt;
  logic        err_r, err_nxt;
  logic        swl_r, swl_nxt;
  logic        run_r, run_nxt;
  logic [1:0]  pend_r, pend_nxt;

  logic [4:0]  key;
  logic        halted;
  logic [17:0] mpc;
  logic        do_plain;
  logic        acc_go, acc_wr;
  logic [17:0] acc_a;
  logic [15:0] acc_d;
  logic [2:0]  cpu_cmd;
  logic [2:0]  acc_cmd;
  logic [17:0] acc_addr;
  logic [15:0] acc_wdata;

  assign key    = item.data.key_code;
  assign halted = item.data.cpu_halted;
  assign mpc    = 18'(item.data.micro_pc & MPC_MASK);

  always_comb begin
    entry_nxt  = entry_r;
    ptr_nxt    = ptr_r;
    shown_nxt  = shown_r;
    sw_nxt     = sw_r;
    exam_nxt   = exam_r;
    dep_nxt    = dep_r;
    mclk_nxt   = mclk_r;
    prefix_nxt = prefix_r;
    maint_nxt  = maint_r;
    err_nxt    = err_r;
    swl_nxt    = swl_r;
    run_nxt    = run_r;
    pend_nxt   = pend_r;
    do_plain   = 1'b0;
    acc_go     = 1'b0;
    acc_wr     = 1'b0;
    acc_a      = REG_HI;
    acc_d      = 16'd0;
    cpu_cmd    = CPU_NONE;

    unique case (item.mode)
      MODE_KEY: begin
        if (pend_r == PEND_NONE) begin
          if (key == KEY_CTRL) begin
            prefix_nxt = !prefix_r;
          end else if (prefix_r) begin
            prefix_nxt = 1'b0;
            unique case (key)
              KEY_HALT: begin
                if (halted) begin
                  cpu_cmd  = CPU_STEP;
                  pend_nxt = PEND_STEP;
                end else begin
                  cpu_cmd = CPU_HALT;
                  acc_go  = 1'b1;
                end
              end
              KEY_PROCEED: begin
                cpu_cmd   = CPU_CONT;
                shown_nxt = 18'(sw_r);
                swl_nxt   = 1'b1;
              end
              KEY_RUN: begin
                if (halted) begin
                  acc_go    = 1'b1;
                  acc_wr    = 1'b1;
                  acc_d     = ptr_r[15:0];
                  cpu_cmd   = CPU_START;
                  shown_nxt = 18'(sw_r);
                  swl_nxt   = 1'b1;
                end
              end
              KEY_LOAD_BOOT: begin
                if (halted) begin
                  cpu_cmd   = CPU_BOOT;
                  shown_nxt = 18'(sw_r);
                  swl_nxt   = 1'b1;
                end
              end
              KEY_SYSINIT: begin
                if (halted) begin
                  cpu_cmd = CPU_INIT;
                end
              end
              KEY_ADD_PTR: begin
                entry_nxt = ptr_r + entry_r + 18'd2;
                shown_nxt = entry_nxt;
              end
              KEY_ADD_SW: begin
                entry_nxt = entry_r + 18'(sw_r);
                shown_nxt = entry_nxt;
              end
              KEY_MAINT: begin
                maint_nxt = 1'b1;
                cpu_cmd   = CPU_HALT;
                shown_nxt = mpc;
              end
              default: begin
                do_plain = (key <= KEY_SYSINIT);
              end
            endcase
          end else begin
            do_plain = (key <= KEY_SYSINIT);
          end
        end
      end
      MODE_ACC: begin
        if (pend_r == PEND_READ) begin
          entry_nxt = 18'(item.data.read_data);
          shown_nxt = 18'(item.data.read_data);
          err_nxt   = item.data.access_error;
          pend_nxt  = PEND_NONE;
        end else if (pend_r == PEND_WRITE) begin
          err_nxt  = item.data.access_error;
          pend_nxt = PEND_NONE;
        end
      end
      MODE_STEP: begin
        if (pend_r == PEND_STEP) begin
          pend_nxt = PEND_NONE;
          if (maint_r) begin
            shown_nxt = mpc;
          end else begin
            acc_go = 1'b1;
          end
        end
      end
      MODE_TICK: begin
        if (pend_r == PEND_NONE) begin
          run_nxt = !halted;
          if (run_r && halted) begin
            acc_go  = 1'b1;
            swl_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    if (do_plain) begin
      if (maint_r) begin
        unique case (key)
          KEY_CLR: begin
            mclk_nxt  = 1'b0;
            maint_nxt = 1'b0;
            err_nxt   = 1'b0;
            swl_nxt   = 1'b0;
            cpu_cmd   = CPU_HALT;
            acc_go    = 1'b1;
          end
          KEY_DISAD: shown_nxt = item.data.cpu_bus_address;
          KEY_VIEW:  shown_nxt = 18'(item.data.cpu_bus_data);
          KEY_HALT: begin
            mclk_nxt  = 1'b1;
            cpu_cmd   = CPU_HALT;
            shown_nxt = mpc;
          end
          KEY_PROCEED: begin
            mclk_nxt = 1'b1;
            cpu_cmd  = CPU_USTEP;
            pend_nxt = PEND_STEP;
          end
          KEY_LOAD_BOOT: cpu_cmd = CPU_BOOT;
          KEY_RUN: begin
            mclk_nxt  = 1'b0;
            shown_nxt = mpc;
          end
          default: begin
          end
        endcase
      end else if (key <= KEY_DIGIT_MAX) begin
        entry_nxt = {entry_r[14:0], key[2:0]};
        shown_nxt = {entry_r[14:0], key[2:0]};
        err_nxt   = 1'b0;
        swl_nxt   = 1'b0;
      end else begin
        unique case (key)
          KEY_CLR: begin
            entry_nxt = 18'd0;
            shown_nxt = 18'd0;
            err_nxt   = 1'b0;
            swl_nxt   = 1'b0;
            exam_nxt  = 1'b0;
            dep_nxt   = 1'b0;
            maint_nxt = 1'b0;
          end
          KEY_LAD: begin
            ptr_nxt   = entry_r;
            entry_nxt = 18'd0;
            shown_nxt = 18'd0;
            err_nxt   = 1'b0;
            swl_nxt   = 1'b0;
          end
          KEY_LSR: begin
            sw_nxt    = entry_r[15:0];
            shown_nxt = 18'(entry_r[15:0]);
            swl_nxt   = 1'b1;
          end
          KEY_DISAD: begin
            shown_nxt = ptr_r;
            exam_nxt  = 1'b0;
            dep_nxt   = 1'b0;
          end
          KEY_VIEW: begin
            if (halted) begin
              if (exam_r) begin
                ptr_nxt = ptr_r + 18'd2;
              end
              acc_go   = 1'b1;
              acc_a    = ptr_nxt;
              exam_nxt = 1'b1;
              dep_nxt  = 1'b0;
            end
          end
          KEY_DEP: begin
            if (halted) begin
              if (dep_r) begin
                ptr_nxt = ptr_r + 18'd2;
              end
              acc_go   = 1'b1;
              acc_wr   = 1'b1;
              acc_a    = ptr_nxt;
              acc_d    = entry_r[15:0];
              dep_nxt  = 1'b1;
              exam_nxt = 1'b0;
            end
          end
          KEY_HALT: begin
            if (halted) begin
              cpu_cmd  = CPU_STEP;
              pend_nxt = PEND_STEP;
            end
          end
          default: begin
          end
        endcase
      end
    end

    acc_cmd   = ACC_NONE;
    acc_addr  = 18'd0;
    acc_wdata = 16'd0;
    if (acc_go) begin
      pend_nxt  = acc_wr ? PEND_WRITE : PEND_READ;
      acc_wdata = acc_wr ? acc_d : 16'd0;
      if (acc_a >= REG_LO && acc_a <= REG_HI) begin
        acc_cmd  = acc_wr ? ACC_REG_WR : ACC_REG_RD;
        acc_addr = {15'd0, acc_a[2:0]};
      end else begin
        acc_cmd  = acc_wr ? ACC_BUS_WR : ACC_BUS_RD;
        acc_addr = acc_a & EVEN_MASK;
      end
    end
  end

  always_comb begin
    result.display_value        = shown_nxt;
    result.switch_value         = sw_nxt;
    result.run_light            = run_nxt;
    result.bus_error_light      = err_nxt;
    result.switch_display_light = swl_nxt;
    result.maintenance_light    = maint_nxt;
    result.control_armed        = prefix_nxt;
    result.manual_clock         = mclk_nxt;
    result.access_command       = acc_cmd;
    result.access_address       = acc_addr;
    result.access_write_data    = acc_wdata;
    result.cpu_command          = cpu_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r  <= 18'd0;
      ptr_r    <= 18'd0;
      shown_r  <= 18'd0;
      sw_r     <= 16'd0;
      exam_r   <= 1'b0;
      dep_r    <= 1'b0;
      mclk_r   <= 1'b0;
      prefix_r <= 1'b0;
      maint_r  <= 1'b0;
      err_r    <= 1'b0;
      swl_r    <= 1'b0;
      run_r    <= 1'b0;
      pend_r   <= PEND_NONE;
    end else if (ctl.fire) begin
      entry_r  <= entry_nxt;
      ptr_r    <= ptr_nxt;
      shown_r  <= shown_nxt;
      sw_r     <= sw_nxt;
      exam_r   <= exam_nxt;
      dep_r    <= dep_nxt;
      mclk_r   <= mclk_nxt;
      prefix_r <= prefix_nxt;
      maint_r  <= maint_nxt;
      err_r    <= err_nxt;
      swl_r    <= swl_nxt;
      run_r    <= run_nxt;
      pend_r   <= pend_nxt;
    end
  end

endmodule

/* sv/okc_out_stage.sv */
// Result register of the console controller: holds one word until taken.
// Depends on okc_pkg.
module okc_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  okc_pkg::stage_ctl_t ctl,
  input  okc_pkg::out_item_t  result,
  output logic                out_valid,
  output okc_pkg::out_item_t  out_item
);
  import okc_pkg::*;

  logic      valid_r, valid_nxt;
  out_item_t item_r;

  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.adv) begin
      valid_nxt = ctl.fire;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      item_r <= result;
    end
  end

endmodule

/* sv/octal_keypad_console_controller_unit.sv */
// Top level of the octal keypad console controller.
// Depends on okc_pkg, okc_in_stage, okc_core, okc_out_stage.
//
//   channel  tvalid/tready      tdata / tuser
//   in_      key/completion     tdata 72b item fields, tuser 2b kind
//   out_     console result     tdata 80b lamps, display, access, command
//
// One word is accepted per cycle when both registers can move.
// A word taken into the input register moves into the result register once that register can load.
// The console state is updated when a word moves into the result register.
// A stalled result holds the input register; ready falls only when both are full.
// Synchronous active-low reset clears the console state and both valid flags.
module octal_keypad_console_controller_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // key_code, read_data, access_error, cpu_halted, micro_pc,
  // cpu_bus_address, cpu_bus_data, zero pad
  input  logic [okc_pkg::IN_DATA_W-1:0]   in_tdata,
  // mode
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // display_value, switch_value, run_light, bus_error_light,
  // switch_display_light, maintenance_light, control_armed, manual_clock,
  // access_command, access_address, access_write_data, cpu_command
  output logic [okc_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import okc_pkg::*;

  in_item_t   in_item;
  in_item_t   held_item;
  logic       held_valid;
  out_item_t  result;
  out_item_t  out_item;
  stage_ctl_t ctl;

  assign in_item.mode = in_tuser;
  assign in_item.data = in_data_t'(in_tdata);

  assign ctl.adv  = !out_tvalid || out_tready;
  assign ctl.fire = held_valid && ctl.adv;

  okc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .ctl        (ctl),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  okc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .item   (held_item),
    .result (result)
  );

  okc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .result    (result),
    .out_valid (out_tvalid),
    .out_item  (out_item)
  );

  assign out_tdata = OUT_DATA_W'(out_item);

endmodule

/* sv/okc_checker.sv */
// Port-level checks for the console controller, bound to the top level.
// Depends on okc_pkg and octal_keypad_console_controller_unit.
module okc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [okc_pkg::OUT_DATA_W-1:0] out_tdata
);
  import okc_pkg::*;

  out_item_t o;
  assign o = out_item_t'(out_tdata);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

  a_reg_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (o.access_command == ACC_REG_RD || o.access_command == ACC_REG_WR)
      |-> o.access_address[17:3] == 15'd0)
    else $error("register access beyond register 7");

  a_acc_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (o.access_command == ACC_NONE || o.access_command == ACC_BUS_RD ||
      o.access_command == ACC_BUS_WR || o.access_command == ACC_REG_RD ||
      o.access_command == ACC_REG_WR) &&
      (o.access_command != ACC_BUS_RD || o.access_write_data == 16'd0))
    else $error("bad access command or read with write data");

endmodule

bind octal_keypad_console_controller_unit okc_checker u_okc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* tb/okc_console_checker.sv */
// Result checker for the octal keypad console controller testbench.
// Watches both stream channels, predicts each console result and compares it.
// Depends on okc_pkg.
module okc_console_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [okc_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]                     in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [okc_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                             mismatches,
  output int                             outstanding,
  output int                             results_seen
);
  import okc_pkg::*;

  // predicted console state
  logic [17:0] entry_reg, addr_pointer, shown;
  logic [15:0] sw_word;
  logic        exam_armed, dep_armed, mclk_on, cntrl_on, maint_on;
  logic        err_lamp, sw_lamp, run_lamp;
  logic [1:0]  pend;

  // commands issued by the word being predicted
  logic [2:0]  acc_cmd, cpu_cmd;
  logic [17:0] acc_addr;
  logic [15:0] acc_wdata;

  out_item_t console_q[$];
  int        bad_count = 0;
  int        n_results = 0;

  function automatic void clear_console();
    entry_reg = '0; addr_pointer = '0; shown = '0; sw_word = '0;
    exam_armed = 1'b0; dep_armed = 1'b0; mclk_on = 1'b0; cntrl_on = 1'b0;
    maint_on = 1'b0; err_lamp = 1'b0; sw_lamp = 1'b0; run_lamp = 1'b0;
    pend = PEND_NONE;
  endfunction

  function automatic void issue_access(logic wr, logic [17:0] addr, logic [17:0] data);
    if (addr >= REG_LO && addr <= REG_HI) begin
      acc_cmd  = wr ? ACC_REG_WR : ACC_REG_RD;
      acc_addr = {15'd0, addr[2:0]};
    end else begin
      acc_cmd  = wr ? ACC_BUS_WR : ACC_BUS_RD;
      acc_addr = addr & EVEN_MASK;
    end
    acc_wdata = wr ? data[15:0] : 16'd0;
    pend      = wr ? PEND_WRITE : PEND_READ;
  endfunction

  function automatic void fetch_pc();
    issue_access(1'b0, REG_HI, 18'd0);
  endfunction

  function automatic void show_switch_reg();
    shown   = {2'b00, sw_word};
    sw_lamp = 1'b1;
  endfunction

  function automatic void begin_step();
    cpu_cmd = CPU_STEP;
    pend    = PEND_STEP;
  endfunction

  function automatic void maint_key_press(logic [4:0] key, in_data_t d);
    case (key)
      KEY_CLR: begin
        mclk_on = 1'b0; maint_on = 1'b0; err_lamp = 1'b0; sw_lamp = 1'b0;
        cpu_cmd = CPU_HALT;
        fetch_pc();
      end
      KEY_DISAD: shown = d.cpu_bus_address;
      KEY_VIEW:  shown = {2'b00, d.cpu_bus_data};
      KEY_HALT: begin
        mclk_on = 1'b1; cpu_cmd = CPU_HALT; shown = 18'(d.micro_pc & MPC_MASK);
      end
      KEY_PROCEED: begin
        mclk_on = 1'b1; cpu_cmd = CPU_USTEP; pend = PEND_STEP;
      end
      KEY_LOAD_BOOT: cpu_cmd = CPU_BOOT;
      KEY_RUN: begin
        mclk_on = 1'b0; shown = 18'(d.micro_pc & MPC_MASK);
      end
      default: ;
    endcase
  endfunction

  function automatic void plain_key_press(logic [4:0] key, in_data_t d);
    if (maint_on) begin
      maint_key_press(key, d);
    end else if (key <= KEY_DIGIT_MAX) begin
      entry_reg = {entry_reg[14:0], key[2:0]};
      shown = entry_reg; err_lamp = 1'b0; sw_lamp = 1'b0;
    end else begin
      case (key)
        KEY_CLR: begin
          entry_reg = '0; shown = '0; err_lamp = 1'b0; sw_lamp = 1'b0;
          exam_armed = 1'b0; dep_armed = 1'b0; maint_on = 1'b0;
        end
        KEY_LAD: begin
          addr_pointer = entry_reg; entry_reg = '0; shown = '0;
          err_lamp = 1'b0; sw_lamp = 1'b0;
        end
        KEY_LSR: begin
          sw_word = entry_reg[15:0];
          show_switch_reg();
        end
        KEY_DISAD: begin
          shown = addr_pointer; exam_armed = 1'b0; dep_armed = 1'b0;
        end
        KEY_VIEW: if (d.cpu_halted) begin
          if (exam_armed) addr_pointer = addr_pointer + 18'd2;
          issue_access(1'b0, addr_pointer, 18'd0);
          exam_armed = 1'b1; dep_armed = 1'b0;
        end
        KEY_DEP: if (d.cpu_halted) begin
          if (dep_armed) addr_pointer = addr_pointer + 18'd2;
          issue_access(1'b1, addr_pointer, entry_reg);
          dep_armed = 1'b1; exam_armed = 1'b0;
        end
        KEY_HALT: if (d.cpu_halted) begin_step();
        default: ;
      endcase
    end
  endfunction

  function automatic void cntrl_key_press(logic [4:0] key, in_data_t d);
    cntrl_on = 1'b0;
    case (key)
      KEY_HALT: begin
        if (d.cpu_halted) begin
          begin_step();
        end else begin
          cpu_cmd = CPU_HALT;
          fetch_pc();
        end
      end
      KEY_PROCEED: begin
        cpu_cmd = CPU_CONT;
        show_switch_reg();
      end
      KEY_RUN: if (d.cpu_halted) begin
        issue_access(1'b1, REG_HI, addr_pointer);
        cpu_cmd = CPU_START;
        show_switch_reg();
      end
      KEY_LOAD_BOOT: if (d.cpu_halted) begin
        cpu_cmd = CPU_BOOT;
        show_switch_reg();
      end
      KEY_SYSINIT: if (d.cpu_halted) cpu_cmd = CPU_INIT;
      KEY_ADD_PTR: begin
        entry_reg = addr_pointer + entry_reg + 18'd2;
        shown = entry_reg;
      end
      KEY_ADD_SW: begin
        entry_reg = entry_reg + {2'b00, sw_word};
        shown = entry_reg;
      end
      KEY_MAINT: begin
        maint_on = 1'b1; cpu_cmd = CPU_HALT; shown = 18'(d.micro_pc & MPC_MASK);
      end
      default: if (key <= KEY_SYSINIT) plain_key_press(key, d);
    endcase
  endfunction

  function automatic out_item_t console_update(logic [1:0] mode, in_data_t d);
    out_item_t r;
    logic      prev_run;
    acc_cmd = ACC_NONE; acc_addr = '0; acc_wdata = '0; cpu_cmd = CPU_NONE;
    case (mode)
      MODE_KEY: if (pend == PEND_NONE) begin
        if (d.key_code == KEY_CTRL) cntrl_on = ~cntrl_on;
        else if (cntrl_on) cntrl_key_press(d.key_code, d);
        else if (d.key_code <= KEY_SYSINIT) plain_key_press(d.key_code, d);
      end
      MODE_ACC: begin
        if (pend == PEND_READ) begin
          entry_reg = {2'b00, d.read_data};
          shown     = entry_reg;
          err_lamp  = d.access_error;
          pend      = PEND_NONE;
        end else if (pend == PEND_WRITE) begin
          err_lamp = d.access_error;
          pend     = PEND_NONE;
        end
      end
      MODE_STEP: if (pend == PEND_STEP) begin
        pend = PEND_NONE;
        if (maint_on) shown = 18'(d.micro_pc & MPC_MASK);
        else fetch_pc();
      end
      default: if (pend == PEND_NONE) begin
        prev_run = run_lamp;
        run_lamp = ~d.cpu_halted;
        if (prev_run && !run_lamp) begin
          fetch_pc();
          sw_lamp = 1'b0;
        end
      end
    endcase
    r.display_value        = shown;
    r.switch_value         = sw_word;
    r.run_light            = run_lamp;
    r.bus_error_light      = err_lamp;
    r.switch_display_light = sw_lamp;
    r.maintenance_light    = maint_on;
    r.control_armed        = cntrl_on;
    r.manual_clock         = mclk_on;
    r.access_command       = acc_cmd;
    r.access_address       = acc_addr;
    r.access_write_data    = acc_wdata;
    r.cpu_command          = cpu_cmd;
    return r;
  endfunction

  function automatic void check_field(string name, logic [17:0] want, logic [17:0] got);
    if (got !== want) begin
      bad_count++;
      if (bad_count <= 10)
        $display("mismatch in %s of result %0d: expected %0h, got %0h",
                 name, n_results, want, got);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (!rst_n) begin
      clear_console();
      console_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_item_t'(out_tdata);
        if (console_q.size() == 0) begin
          bad_count++;
          if (bad_count <= 10) $display("unexpected result word %0h", out_tdata);
        end else begin
          want = console_q.pop_front();
          check_field("display_value", want.display_value, got.display_value);
          check_field("switch_value", 18'(want.switch_value), 18'(got.switch_value));
          check_field("run_light", 18'(want.run_light), 18'(got.run_light));
          check_field("bus_error_light", 18'(want.bus_error_light),
                      18'(got.bus_error_light));
          check_field("switch_display_light", 18'(want.switch_display_light),
                      18'(got.switch_display_light));
          check_field("maintenance_light", 18'(want.maintenance_light),
                      18'(got.maintenance_light));
          check_field("control_armed", 18'(want.control_armed), 18'(got.control_armed));
          check_field("manual_clock", 18'(want.manual_clock), 18'(got.manual_clock));
          check_field("access_command", 18'(want.access_command),
                      18'(got.access_command));
          check_field("access_address", want.access_address, got.access_address);
          check_field("access_write_data", 18'(want.access_write_data),
                      18'(got.access_write_data));
          check_field("cpu_command", 18'(want.cpu_command), 18'(got.cpu_command));
        end
        n_results++;
      end
      if (in_tvalid && in_tready)
        console_q.push_back(console_update(in_tuser, in_data_t'(in_tdata)));
    end
    mismatches   <= bad_count;
    outstanding  <= console_q.size();
    results_seen <= n_results;
  end

endmodule

/* tb/tb_octal_keypad_console_controller_unit.sv */
// Testbench top for the octal keypad console controller.
// Drives keypad, completion and status words with random stalls and gives the verdict.
// Depends on okc_pkg, okc_console_checker and the controller RTL.
module tb_octal_keypad_console_controller_unit;
  import okc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int WORD_TARGET = 1900;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  int mismatches, outstanding, results_seen;
  int words_sent = 0;
  int cycle_count = 0;
  bit calm = 1'b0;
  bit halted_now = 1'b1;

  octal_keypad_console_controller_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  okc_console_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .mismatches(mismatches), .outstanding(outstanding), .results_seen(results_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= 10);
  end

  function automatic in_data_t make_word(logic [4:0] key);
    in_data_t d;
    d.pad             = '0;
    d.key_code        = key;
    d.read_data       = 16'($urandom_range(0, 65535));
    d.access_error    = ($urandom_range(0, 9) == 0);
    d.cpu_halted      = halted_now;
    d.micro_pc        = 9'($urandom_range(0, 511));
    d.cpu_bus_address = 18'($urandom_range(0, 262143));
    d.cpu_bus_data    = 16'($urandom_range(0, 65535));
    return d;
  endfunction

  task automatic send_word(logic [1:0] mode, in_data_t d);
    while (!calm && $urandom_range(0, 99) < 10) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= mode;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic press(logic [4:0] key);
    send_word(MODE_KEY, make_word(key));
  endtask

  task automatic access_done(logic err, logic [15:0] data);
    in_data_t d;
    d = make_word(5'($urandom_range(0, 31)));
    d.access_error = err;
    d.read_data = data;
    send_word(MODE_ACC, d);
  endtask

  task automatic step_done();
    send_word(MODE_STEP, make_word(5'($urandom_range(0, 31))));
  endtask

  task automatic status_tick();
    send_word(MODE_TICK, make_word(5'($urandom_range(0, 31))));
  endtask

  // most times sends a step and an access completion for whatever the last key may have started
  task automatic settle();
    if ($urandom_range(0, 99) < 85) begin
      step_done();
      access_done($urandom_range(0, 9) == 0, 16'($urandom_range(0, 65535)));
    end
  endtask

  // stop sending until every predicted result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic random_op();
    logic [4:0] desk_keys[4]   = '{KEY_CLR, KEY_LAD, KEY_LSR, KEY_DISAD};
    logic [4:0] cntrl_keys[12] = '{KEY_HALT, KEY_PROCEED, KEY_LOAD_BOOT, KEY_RUN,
                                   KEY_SYSINIT, KEY_ADD_PTR, KEY_ADD_SW, KEY_MAINT,
                                   KEY_CLR, KEY_VIEW, KEY_DEP, KEY_CTRL};
    logic [4:0] maint_keys[10] = '{KEY_CLR, KEY_DISAD, KEY_VIEW, KEY_HALT, KEY_PROCEED,
                                   KEY_LOAD_BOOT, KEY_RUN, KEY_LAD, KEY_DEP, KEY_SYSINIT};
    int         pick;
    logic [4:0] k;
    if ($urandom_range(0, 9) == 0) halted_now = ($urandom_range(0, 3) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      repeat ($urandom_range(1, 6)) press(5'($urandom_range(0, 7)));
    end else if (pick < 35) begin
      press(desk_keys[$urandom_range(0, 3)]);
    end else if (pick < 55) begin
      press($urandom_range(0, 1) ? KEY_VIEW : KEY_DEP);
      settle();
    end else if (pick < 70) begin
      k = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                       : cntrl_keys[$urandom_range(0, 11)];
      press(KEY_CTRL);
      press(k);
      settle();
      if (k == KEY_MAINT) begin
        repeat ($urandom_range(1, 4)) begin
          press(($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                            : maint_keys[$urandom_range(0, 9)]);
          settle();
        end
        if ($urandom_range(0, 9) < 7) begin
          press(KEY_CLR);
          settle();
        end
      end
    end else if (pick < 78) begin
      press(KEY_HALT);
      settle();
    end else if (pick < 90) begin
      status_tick();
      settle();
    end else begin
      halted_now = 1'($urandom_range(0, 1));
      send_word(2'($urandom_range(0, 3)), make_word(5'($urandom_range(0, 31))));
    end
  endtask

  initial begin
    bit paused = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full-scale entry, pointer wrap on repeated examine, error lamp
    halted_now = 1'b1;
    repeat (6) press(5'd7);
    press(KEY_LAD);
    press(KEY_VIEW);
    access_done(1'b1, 16'hFFFF);
    press(KEY_VIEW);
    access_done(1'b0, 16'h0000);
    // start writes R7, halt while running reads R7
    press(KEY_CTRL);
    press(KEY_RUN);
    access_done(1'b0, 16'h0000);
    halted_now = 1'b0;
    press(KEY_CTRL);
    press(KEY_HALT);
    access_done(1'b0, 16'h1234);
    status_tick();
    halted_now = 1'b1;
    status_tick();
    access_done(1'b0, 16'h0000);
    // maintenance microstep, exit by clear
    press(KEY_CTRL);
    press(KEY_MAINT);
    press(KEY_PROCEED);
    step_done();
    press(KEY_CLR);
    access_done(1'b0, 16'h0000);
    press(5'd31);
    press(KEY_CTRL);
    press(5'd31);
    drain();

    while (words_sent < WORD_TARGET) begin
      calm <= (words_sent >= 900 && words_sent < 1200);
      if (!paused && words_sent > 1500) begin
        drain();
        paused = 1'b1;
      end
      random_op();
    end
    drain();
    repeat (8) @(posedge clk);

    $display("covered %0d words in, %0d results out: octal entry, examine/deposit,",
             words_sent, results_seen);
    $display("register accesses, CNTRL commands, maintenance mode and stray completions");
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
